// File: rtl/cdi_pkg.sv
package cdi_pkg;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_GET    = 2'd2,
        CMD_SET    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_RANGE = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

endpackage

// File: rtl/cdi_ram.sv
module cdi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
)(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/circular_deque_indexed.sv
// Indexed list in a ring of CAPACITY words, one command per start pulse: insert, remove,
// get or set at a logical index from the front. Errors (index out of range, insert into a
// full list) give their result the cycle after start without raising busy. Get, set and
// inserts or removals at either end go from the fetch or final state to done. A middle
// insert or removal moves the front part of the list by one place if the index is under
// (insert) or at most (remove) half the count, else the back part, one word per cycle
// through the single-port-pair element RAM. Each result appears for one cycle with done
// high and cannot be held off; the next start is taken in the same cycle as done.
module circular_deque_indexed
    import cdi_pkg::*;
#(
    parameter int CAPACITY    = 64,
    parameter int VALUE_WIDTH = 32
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [1:0]  cmd,
    input  logic [6:0]  position,
    input  logic [31:0] item_value,
    output logic        busy,
    output logic        done,
    output logic [31:0] result_value,
    output logic [6:0]  item_count,
    output logic [1:0]  status
);

    localparam int AW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > 7) ? CW : 7;
    localparam logic [AW:0]     CAP_W     = (AW + 1)'(CAPACITY);
    localparam logic [AW-1:0]   LAST_SLOT = AW'(CAPACITY - 1);
    localparam logic [CMPW-1:0] CAP_C     = CMPW'(CAPACITY);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_FETCH = 4'b0010,
        S_MOVE  = 4'b0100,
        S_FINAL = 4'b1000
    } state_t;

    state_t                 state_reg, state_next;
    logic [AW-1:0]          head_reg, head_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [AW-1:0]          src_reg, src_next;
    logic [AW-1:0]          dst_reg, dst_next;
    logic                   fwd_reg, fwd_next;
    logic [CW-1:0]          rd_left_reg, rd_left_next;
    logic [CW-1:0]          wr_left_reg, wr_left_next;
    logic                   pend_reg, pend_next;
    cmd_t                   op_reg, op_next;
    logic [VALUE_WIDTH-1:0] val_reg, val_next;
    logic                   done_reg, done_next;
    logic [31:0]            res_reg, res_next;
    logic [6:0]             cnt_out_reg, cnt_out_next;
    status_t                stat_reg, stat_next;

    logic                   ram_we, ram_re;
    logic [AW-1:0]          ram_waddr, ram_raddr;
    logic [VALUE_WIDTH-1:0] ram_wdata, ram_rdata;

    logic [CMPW-1:0]        pos_w, cnt_w, half_w;
    logic [AW:0]            pos_a, cnt_a;
    logic [CW-1:0]          pos_c;
    logic [AW-1:0]          pos_slot, end_slot;
    logic [63:0]            in_wide, rd_wide;
    logic [VALUE_WIDTH-1:0] new_val;
    logic [31:0]            rd_val32;
    logic                   accept;
    cmd_t                   cmd_c;

    function automatic logic [AW-1:0] slot_at(input logic [AW-1:0] h, input logic [AW:0] x);
        logic [AW:0] s;
        s = (AW + 1)'(h) + x;
        if (s >= CAP_W)
        begin
            s = s - CAP_W;
        end
        return s[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] step_up(input logic [AW-1:0] p);
        return (p == LAST_SLOT) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [AW-1:0] step_down(input logic [AW-1:0] p);
        return (p == '0) ? LAST_SLOT : p - 1'b1;
    endfunction

    cdi_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign busy         = (state_reg != S_IDLE);
    assign accept       = start && !busy;
    assign cmd_c        = cmd_t'(cmd);
    assign done         = done_reg;
    assign result_value = res_reg;
    assign item_count   = cnt_out_reg;
    assign status       = stat_reg;

    assign pos_w    = CMPW'(position);
    assign cnt_w    = CMPW'(count_reg);
    assign half_w   = cnt_w >> 1;
    assign pos_a    = (AW + 1)'(position);
    assign cnt_a    = (AW + 1)'(count_reg);
    assign pos_c    = CW'(position);
    assign pos_slot = slot_at(head_reg, pos_a);
    assign end_slot = slot_at(head_reg, cnt_a);

    assign in_wide  = {32'd0, item_value};
    assign new_val  = in_wide[VALUE_WIDTH-1:0];
    assign rd_wide  = 64'(ram_rdata);
    assign rd_val32 = rd_wide[31:0];

    assign ram_wdata = (state_reg == S_MOVE) ? ram_rdata : val_reg;

    always_comb
    begin
        logic is_insert;
        logic range_err;
        logic [CW-1:0] moves;

        state_next   = state_reg;
        head_next    = head_reg;
        count_next   = count_reg;
        src_next     = src_reg;
        dst_next     = dst_reg;
        fwd_next     = fwd_reg;
        rd_left_next = rd_left_reg;
        wr_left_next = wr_left_reg;
        pend_next    = 1'b0;
        op_next      = op_reg;
        val_next     = val_reg;
        done_next    = 1'b0;
        res_next     = res_reg;
        cnt_out_next = cnt_out_reg;
        stat_next    = stat_reg;
        ram_we       = 1'b0;
        ram_waddr    = dst_reg;
        ram_re       = 1'b0;
        ram_raddr    = src_reg;
        is_insert    = 1'b0;
        range_err    = 1'b0;
        moves        = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (cmd_c)
                        CMD_INSERT:
                        begin
                            is_insert = 1'b1;
                            range_err = (pos_w > cnt_w);
                        end
                        CMD_SET:
                        begin
                            is_insert = (pos_w == cnt_w);
                            range_err = (pos_w > cnt_w);
                        end
                        default:
                        begin
                            range_err = (pos_w >= cnt_w);
                        end
                    endcase

                    val_next = new_val;
                    res_next = '0;

                    if (range_err || (is_insert && cnt_w == CAP_C))
                    begin
                        // answer straight away, nothing changes
                        done_next    = 1'b1;
                        cnt_out_next = cnt_w[6:0];
                        stat_next    = range_err ? STAT_RANGE : STAT_FULL;
                    end
                    else if (is_insert)
                    begin
                        op_next    = CMD_INSERT;
                        count_next = count_reg + 1'b1;
                        if (count_reg == '0)
                        begin
                            head_next = '0;
                            dst_next  = '0;
                        end
                        else if (pos_w == '0 || pos_w < half_w)
                        begin
                            // open a gap at the front: head steps back
                            head_next = step_down(head_reg);
                            dst_next  = step_down(head_reg);
                            src_next  = head_reg;
                            fwd_next  = 1'b1;
                            moves     = pos_c;
                        end
                        else
                        begin
                            dst_next = end_slot;
                            src_next = step_down(end_slot);
                            fwd_next = 1'b0;
                            moves    = count_reg - pos_c;
                        end
                        rd_left_next = moves;
                        wr_left_next = moves;
                        state_next   = (moves == '0) ? S_FINAL : S_MOVE;
                    end
                    else
                    begin
                        op_next   = cmd_c;
                        ram_re    = 1'b1;
                        ram_raddr = pos_slot;
                        dst_next  = pos_slot;
                        if (cmd_c == CMD_REMOVE)
                        begin
                            count_next = count_reg - 1'b1;
                            if (pos_w == '0 || (pos_w != cnt_w - 1'b1 && pos_w <= half_w))
                            begin
                                // close the gap from the front: head steps forward
                                head_next = step_up(head_reg);
                                src_next  = step_down(pos_slot);
                                fwd_next  = 1'b0;
                                moves     = pos_c;
                            end
                            else
                            begin
                                src_next = step_up(pos_slot);
                                fwd_next = 1'b1;
                                moves    = count_reg - 1'b1 - pos_c;
                            end
                        end
                        rd_left_next = moves;
                        wr_left_next = moves;
                        state_next   = S_FETCH;
                    end
                end
            end

            S_FETCH:
            begin
                res_next     = rd_val32;
                cnt_out_next = cnt_w[6:0];
                stat_next    = STAT_OK;
                case (op_reg)
                    CMD_SET:
                    begin
                        ram_we     = 1'b1;
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                    CMD_REMOVE:
                    begin
                        if (wr_left_reg == '0)
                        begin
                            done_next  = 1'b1;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            state_next = S_MOVE;
                        end
                    end
                    default:
                    begin
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                endcase
            end

            S_MOVE:
            begin
                // read one word ahead, write the word read last cycle
                if (rd_left_reg != '0)
                begin
                    ram_re       = 1'b1;
                    ram_raddr    = src_reg;
                    src_next     = fwd_reg ? step_up(src_reg) : step_down(src_reg);
                    rd_left_next = rd_left_reg - 1'b1;
                    pend_next    = 1'b1;
                end
                if (pend_reg)
                begin
                    ram_we       = 1'b1;
                    dst_next     = fwd_reg ? step_up(dst_reg) : step_down(dst_reg);
                    wr_left_next = wr_left_reg - 1'b1;
                    if (wr_left_reg == CW'(1))
                    begin
                        if (op_reg == CMD_INSERT)
                        begin
                            state_next = S_FINAL;
                        end
                        else
                        begin
                            done_next    = 1'b1;
                            cnt_out_next = cnt_w[6:0];
                            stat_next    = STAT_OK;
                            state_next   = S_IDLE;
                        end
                    end
                end
            end

            S_FINAL:
            begin
                ram_we       = 1'b1;
                res_next     = '0;
                done_next    = 1'b1;
                cnt_out_next = cnt_w[6:0];
                stat_next    = STAT_OK;
                state_next   = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            head_reg    <= '0;
            count_reg   <= '0;
            rd_left_reg <= '0;
            wr_left_reg <= '0;
            pend_reg    <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            count_reg   <= count_next;
            rd_left_reg <= rd_left_next;
            wr_left_reg <= wr_left_next;
            pend_reg    <= pend_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        src_reg     <= src_next;
        dst_reg     <= dst_next;
        fwd_reg     <= fwd_next;
        op_reg      <= op_next;
        val_reg     <= val_next;
        res_reg     <= res_next;
        cnt_out_reg <= cnt_out_next;
        stat_reg    <= stat_next;
    end

endmodule

// File: rtl/cdi_checker.sv
module cdi_checker
    import cdi_pkg::*;
#(
    parameter int CAPACITY = 64
)(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [31:0] result_value,
    input logic [6:0]  item_count,
    input logic [1:0]  status
);

    localparam logic [6:0] FULL_COUNT = 7'(CAPACITY);

    // every accepted command either starts work or answers at once
    a_accept_answered: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy || done)
        else $error("accepted command neither busy nor answered");

    a_done_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result transfer while busy");

    a_end_of_work: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("work ended without a result");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && status != STAT_OK |-> result_value == '0)
        else $error("error result carries a value");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        done && status == STAT_FULL |-> item_count == FULL_COUNT)
        else $error("full status with list not full");

endmodule

bind circular_deque_indexed cdi_checker #(.CAPACITY(CAPACITY)) u_cdi_checker (.*);

// File: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import cdi_pkg::*;

    localparam int DEPTH       = 64;
    localparam int STALL_LIMIT = 2000;
    localparam int ITEMS_PHASE = 330;

    typedef struct {
        logic [31:0] value;
        logic [6:0]  count;
        status_t     st;
    } deque_reply_t;

    // Tracks the logical list only: the physical layout in the ring is not visible.
    class list_tracker;
        logic [31:0]  contents[$];
        deque_reply_t pending_replies[$];
        int           mismatches;

        function void note_command(cmd_t c, logic [6:0] pos, logic [31:0] v);
            deque_reply_t r;
            int           n;
            n       = contents.size();
            r.value = '0;
            r.st    = STAT_OK;
            case (c)
                CMD_INSERT:
                begin
                    if (pos > n)
                        r.st = STAT_RANGE;
                    else if (n >= DEPTH)
                        r.st = STAT_FULL;
                    else
                        contents.insert(pos, v);
                end
                CMD_REMOVE:
                begin
                    if (pos >= n)
                        r.st = STAT_RANGE;
                    else
                    begin
                        r.value = contents[pos];
                        contents.delete(pos);
                    end
                end
                CMD_GET:
                begin
                    if (pos >= n)
                        r.st = STAT_RANGE;
                    else
                        r.value = contents[pos];
                end
                default:
                begin
                    if (pos > n)
                        r.st = STAT_RANGE;
                    else if (pos == n)
                    begin
                        // set at the count appends
                        if (n >= DEPTH)
                            r.st = STAT_FULL;
                        else
                            contents.push_back(v);
                    end
                    else
                    begin
                        r.value        = contents[pos];
                        contents[pos]  = v;
                    end
                end
            endcase
            r.count = 7'(contents.size());
            pending_replies.push_back(r);
        endfunction

        function void check_reply(logic [31:0] value, logic [6:0] count, logic [1:0] st);
            deque_reply_t e;
            if (pending_replies.size() == 0)
            begin
                if (mismatches < 10)
                    $display("%0t: reply with nothing outstanding: value %h count %0d status %0d",
                             $time, value, count, st);
                mismatches++;
                return;
            end
            e = pending_replies.pop_front();
            if (value !== e.value || count !== e.count || st !== e.st)
            begin
                if (mismatches < 10)
                    $display("%0t: reply mismatch: value %h/%h count %0d/%0d status %0d/%0d",
                             $time, e.value, value, e.count, count, e.st, st);
                mismatches++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    cmd_t        cmd;
    logic [6:0]  position;
    logic [31:0] item_value;
    logic        busy;
    logic        done;
    logic [31:0] result_value;
    logic [6:0]  item_count;
    logic [1:0]  status;

    list_tracker tracker = new;
    int          quiet_cycles = 0;
    bit          growing;

    circular_deque_indexed dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            // check the finished command before noting the one taken at this edge
            if (done)
                tracker.check_reply(result_value, item_count, status);
            if (start && !busy)
                tracker.note_command(cmd, position, item_value);
            if (done || (start && !busy))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // Call at a falling edge; returns at the edge that takes the transfer.
    task automatic put_cmd(input cmd_t c, input logic [6:0] pos, input logic [31:0] v);
        start      <= 1'b1;
        cmd        <= c;
        position   <= pos;
        item_value <= v;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic issue(input cmd_t c, input logic [6:0] pos, input logic [31:0] v);
        @(negedge clk);
        put_cmd(c, pos, v);
    endtask

    task automatic run_phase(input int idle_pct, input int n_items);
        int          n;
        int          roll;
        cmd_t        c;
        logic [6:0]  pos;
        logic [31:0] v;
        for (int k = 0; k < n_items; k++)
        begin
            @(negedge clk);
            while ($urandom_range(99) < idle_pct)
            begin
                start      <= 1'b0;
                cmd        <= cmd_t'($urandom_range(3));
                position   <= 7'($urandom_range(127));
                item_value <= $urandom;
                @(negedge clk);
            end
            n = tracker.contents.size();
            // swing between filling to full and draining to empty
            if (n == DEPTH && $urandom_range(3) == 0)
                growing = 1'b0;
            if (n == 0 && $urandom_range(1) == 0)
                growing = 1'b1;
            roll = $urandom_range(99);
            if (growing)
                c = roll < 60 ? CMD_INSERT : roll < 75 ? CMD_REMOVE : roll < 87 ? CMD_GET : CMD_SET;
            else
                c = roll < 15 ? CMD_INSERT : roll < 75 ? CMD_REMOVE : roll < 87 ? CMD_GET : CMD_SET;
            case ($urandom_range(11))
                0:       pos = 7'd0;
                1, 2:    pos = 7'(n);
                3:       pos = 7'(n > 0 ? n - 1 : 0);
                4:       pos = 7'(n + 1);
                5:       pos = 7'($urandom_range(127));
                default: pos = 7'($urandom_range(n));
            endcase
            case ($urandom_range(9))
                0:       v = 32'h0000_0000;
                1:       v = 32'hFFFF_FFFF;
                default: v = $urandom;
            endcase
            put_cmd(c, pos, v);
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        start        = 1'b0;
        cmd          = CMD_INSERT;
        position     = '0;
        item_value   = '0;
        growing      = 1'b1;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        // errors on the empty list
        issue(CMD_GET,    7'd0,   32'h1111_1111);
        issue(CMD_REMOVE, 7'd0,   32'h2222_2222);
        issue(CMD_SET,    7'd1,   32'h3333_3333);
        issue(CMD_INSERT, 7'd127, 32'h4444_4444);
        // build up: empty, append by set, tail, head, left and right middle
        issue(CMD_INSERT, 7'd0,   32'h0000_0000);
        issue(CMD_SET,    7'd1,   32'hFFFF_FFFF);
        issue(CMD_INSERT, 7'd2,   32'hA5A5_A5A5);
        issue(CMD_INSERT, 7'd0,   32'h5A5A_5A5A);
        issue(CMD_INSERT, 7'd1,   32'hC3C3_C3C3);
        issue(CMD_INSERT, 7'd4,   32'h3C3C_3C3C);
        issue(CMD_GET,    7'd0,   32'h0);
        issue(CMD_GET,    7'd5,   32'h0);
        issue(CMD_SET,    7'd2,   32'h1234_5678);
        // right middle, left middle, head and tail removal
        issue(CMD_REMOVE, 7'd4,   32'h0);
        issue(CMD_REMOVE, 7'd1,   32'h0);
        issue(CMD_REMOVE, 7'd0,   32'h0);
        issue(CMD_REMOVE, 7'd2,   32'h0);
        issue(CMD_GET,    7'd1,   32'h0);
        issue(CMD_GET,    7'd127, 32'h0);
        issue(CMD_REMOVE, 7'd64,  32'h0);
        issue(CMD_INSERT, 7'd3,   32'h0);
        issue(CMD_SET,    7'd3,   32'h0);

        run_phase(24, ITEMS_PHASE);
        run_phase(70, ITEMS_PHASE);
        run_phase(0, ITEMS_PHASE);

        @(negedge clk);
        start <= 1'b0;
        while (tracker.pending_replies.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        if (tracker.mismatches == 0 && tracker.pending_replies.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
